/* rtl/core/wildcard_byte_pattern_scanner_macros.svh */
// Assertion macros for the checker file of the scanner.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WBPS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WBPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wbps_pkg.sv */
package wbps_pkg;

    // Default depth of the history chain, in bytes.
    localparam int MAX_PATTERN_DEF = 32;

    // Fixed register geometry.
    localparam int PAT_WORDS    = 4;
    localparam int PAT_BYTES    = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_START      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPAN       = 3'd7;

    // Result status codes.
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_WINDOW    = 2'd2;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] match_position;
    } out_item_t;

    // Expected byte and its care bit, handed to one history cell.
    typedef struct packed {
        logic       care;
        logic [7:0] pat_byte;
    } cell_ref_t;

endpackage

/* rtl/core/wbps_cell.sv */
module wbps_cell
    import wbps_pkg::*;
(
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] byte_in,
    input  cell_ref_t  ref_in,
    output logic [7:0] byte_out,
    output logic       ok
);

    logic [7:0] byte_reg;

    // Take the neighbor's byte on every accepted transfer.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // A wildcard position always agrees; a cared position needs an exact byte.
    assign ok = !ref_in.care || (byte_reg == ref_in.pat_byte);

endmodule

/* rtl/core/wildcard_byte_pattern_scanner.sv */
// Channel    Direction  Handshake             Payload
// in         input      in_valid / in_stall   in_data   (data_byte, last_byte)
// out        output     out_valid / out_stall out_data  (status, match_position)
// cfg        input      cfg_write             cfg_index, cfg_data
//
// One byte is taken every cycle unless the output stalls. The history
// cells and load stage register it, the compare reads them, and the
// output register takes the result. Reset clears the count, the pipeline
// and the configuration; history cells hold no reset. A stalled output
// register holds the whole chain, so in_stall rises only while a result waits.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] pattern_word_reg [PAT_WORDS];
    logic [31:0]           care_mask_reg;
    logic [5:0]            pattern_length_reg;
    logic [31:0]           search_start_reg;
    logic [31:0]           search_span_reg;

    // Pipeline and scan state.
    logic        advance;
    logic        shift;
    logic [31:0] byte_count_reg, byte_count_next;
    logic        s1_valid_reg;
    logic        s1_last_reg;
    logic [31:0] s1_pos_reg;
    logic        scan_done_reg, scan_done_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    // Cell chain wiring.
    logic [7:0]      chain_byte [MAX_PATTERN+1];
    logic            cell_ok    [MAX_PATTERN];
    cell_ref_t       cell_ref   [MAX_PATTERN];
    logic [IDX_W-1:0] cell_j    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] ok_vec;

    logic [8*PAT_BYTES-1:0] pattern_flat;
    logic [LEN_W-1:0]       eff_len;

    // Window arithmetic, one bit wider than the image offsets.
    logic [32:0] len_w;
    logic [32:0] size_w;
    logic [32:0] start_w;
    logic [32:0] win_begin;
    logic [32:0] win_end;
    logic        complete;
    logic        in_window;
    logic        all_ok;
    logic        found;
    logic        window_err;
    logic        emit;

    // The whole chain moves only while the output register can take a result.
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign shift    = in_valid && advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < PAT_WORDS; w++)
            begin
                pattern_word_reg[w] <= '0;
            end
            care_mask_reg      <= '0;
            pattern_length_reg <= 6'd1;
            search_start_reg   <= '0;
            search_span_reg    <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_0: pattern_word_reg[0] <= cfg_data;
                REG_PATTERN_1: pattern_word_reg[1] <= cfg_data;
                REG_PATTERN_2: pattern_word_reg[2] <= cfg_data;
                REG_PATTERN_3: pattern_word_reg[3] <= cfg_data;
                REG_CARE_MASK: care_mask_reg      <= cfg_data[31:0];
                REG_LENGTH:    pattern_length_reg <= cfg_data[5:0];
                REG_START:     search_start_reg   <= cfg_data[31:0];
                REG_SPAN:      search_span_reg    <= cfg_data[31:0];
                default:       ;
            endcase
        end
    end

    // Length in use: zero acts as one, anything too long as the full chain.
    always_comb
    begin
        if (pattern_length_reg == 6'd0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (pattern_length_reg > 6'(MAX_PATTERN))
        begin
            eff_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            eff_len = LEN_W'(pattern_length_reg);
        end
    end

    assign pattern_flat = {pattern_word_reg[3], pattern_word_reg[2],
                           pattern_word_reg[1], pattern_word_reg[0]};

    assign chain_byte[0] = in_data.data_byte;

    // Cell k holds the byte k places back; the newest byte is matched against
    // the last pattern byte, so cell k faces pattern byte (length - 1 - k).
    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_cell
        assign cell_j[g] = IDX_W'(eff_len - LEN_W'(g) - LEN_W'(1));
        assign cell_ref[g].care = (LEN_W'(g) < eff_len) && care_mask_reg[cell_j[g]];
        assign cell_ref[g].pat_byte = pattern_flat[{cell_j[g], 3'b000} +: 8];
        assign ok_vec[g] = cell_ok[g];

        wbps_cell u_cell (
            .clk      (clk),
            .shift    (shift),
            .byte_in  (chain_byte[g]),
            .ref_in   (cell_ref[g]),
            .byte_out (chain_byte[g+1]),
            .ok       (cell_ok[g])
        );
    end

    assign all_ok = &ok_vec;

    // Byte counter, saturating, restarted after the final byte of an image.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        if (in_data.last_byte)
        begin
            byte_count_next = '0;
        end
        else if (byte_count_reg != 32'hFFFF_FFFF)
        begin
            byte_count_next = byte_count_reg + 32'd1;
        end
    end

    // Load stage: remember where the byte just shifted in sits in the image.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_pos_reg     <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            if (in_valid)
            begin
                byte_count_reg <= byte_count_next;
                s1_last_reg    <= in_data.last_byte;
                s1_pos_reg     <= byte_count_reg;
            end
        end
    end

    // Window checks on the item in the load stage.
    assign len_w     = 33'(eff_len);
    assign size_w    = {1'b0, s1_pos_reg} + 33'd1;
    assign start_w   = {1'b0, search_start_reg};
    assign win_begin = size_w - len_w;
    assign win_end   = start_w + {1'b0, search_span_reg};
    assign complete  = size_w >= len_w;
    assign in_window = (win_begin >= start_w) && (size_w <= win_end);

    assign found = s1_valid_reg && !scan_done_reg && complete && in_window && all_ok;

    assign window_err = (len_w > {1'b0, search_span_reg}) || (len_w > size_w) ||
                        (start_w + len_w > size_w);

    assign emit = found || (s1_valid_reg && s1_last_reg && !scan_done_reg);

    // Result selection and scan-done tracking.
    always_comb
    begin
        out_valid_next = emit;
        out_data_next  = out_data_reg;
        scan_done_next = scan_done_reg;
        if (found)
        begin
            out_data_next.status         = STATUS_FOUND;
            out_data_next.match_position = win_begin[31:0];
        end
        else if (emit)
        begin
            out_data_next.status         = window_err ? STATUS_WINDOW : STATUS_NOT_FOUND;
            out_data_next.match_position = '0;
        end
        if (s1_valid_reg)
        begin
            scan_done_next = s1_last_reg ? 1'b0 : (scan_done_reg || found);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            scan_done_reg <= scan_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/wbps_checker.sv */
`include "wildcard_byte_pattern_scanner_macros.svh"

module wbps_checker
    import wbps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_stall,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data
);

    // A result waiting on a stall stays put.
    `WBPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // Only a waiting result may hold back the input side.
    `WBPS_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without a waiting result")

    // Status is always one of the three defined codes.
    `WBPS_ASSERT_NOW(a_status_code, out_valid, out_data.status == STATUS_FOUND || out_data.status == STATUS_NOT_FOUND || out_data.status == STATUS_WINDOW, "undefined status code")

    // Only a found result carries a position.
    `WBPS_ASSERT_NOW(a_pos_zero, out_valid && out_data.status != STATUS_FOUND, out_data.match_position == 32'd0, "position set without a match")

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
